### rtl/core/particle_sphere_distance_splat_unit_assert.svh
`ifndef PARTICLE_SPHERE_DISTANCE_SPLAT_UNIT_ASSERT_SVH
`define PARTICLE_SPHERE_DISTANCE_SPLAT_UNIT_ASSERT_SVH

// same-cycle implication
`define PSDS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psds check failed");

// next-cycle implication
`define PSDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psds check failed");

`endif

### rtl/core/psds_pkg.sv
package psds_pkg;

  localparam int BLOCK_WIDTH_DEF   = 8;
  localparam int FRACTION_BITS_DEF = 12;

  localparam int OP_W      = 2;
  localparam int POS_W     = 18;
  localparam int CELL_W    = 9;
  localparam int VALUE_W   = 19;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int STORE_W   = 20;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SPLAT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH = 2'd1;

  localparam logic [CFG_W-1:0] RADIUS_RST = 16'd4096;
  localparam logic [CFG_W-1:0] SEARCH_RST = 16'd8192;

  localparam logic signed [STORE_W-1:0] STORE_MAX = 20'sd524287;
  localparam logic signed [STORE_W-1:0] STORE_MIN = -20'sd524288;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 19'sd262143;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = -19'sd262144;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SETUP,
    S_MUL,
    S_SUM,
    S_ROOT_GO,
    S_ROOT,
    S_UPDATE,
    S_READ,
    S_RDATA
  } state_t;

  typedef struct packed {
    logic start;
  } sqrt_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;

endpackage

### rtl/core/psds_if.sv
interface psds_in_if import psds_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [CELL_W-1:0]       read_cell;
  modport source (output valid, operation, pos_x, pos_y, pos_z, read_cell, input ready);
  modport sink (input valid, operation, pos_x, pos_y, pos_z, read_cell, output ready);
endinterface

interface psds_out_if import psds_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] cell_value;
  logic [CELL_W-1:0]         value_cell;
  modport source (output valid, cell_value, value_cell, input ready);
  modport sink (input valid, cell_value, value_cell, output ready);
endinterface

interface psds_cfg_if import psds_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/particle_sphere_distance_splat_unit.sv
// channel   dir   beat
// cfg_ch    in    register index and write data, always ready
// in_ch     in    operation, particle position, cell index to read
// out_ch    out   negated cell value and its cell index, one per read
//
// clear: every store entry written, one entry per cycle
// splat: per visited cell, the root is taken in the one-bit-per-cycle square root unit,
//   whose root is DW = max(clog2(BLOCK_WIDTH) + FRACTION_BITS, 17) + 2 bits wide;
//   squares go through one multiplier
// read: the result sits in an output register, held while out_ch stalls
// in_ch is ready only when the sequencer is idle; synchronous active-low reset
`include "particle_sphere_distance_splat_unit_assert.svh"

module particle_sphere_distance_splat_unit import psds_pkg::*; #(
  parameter int BLOCK_WIDTH   = BLOCK_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  psds_cfg_if.sink    cfg_ch,
  psds_in_if.sink     in_ch,
  psds_out_if.source  out_ch
);

  localparam int CW    = (BLOCK_WIDTH > 1) ? $clog2(BLOCK_WIDTH) : 1;
  localparam int CELLS = BLOCK_WIDTH * BLOCK_WIDTH * BLOCK_WIDTH;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = (((CW + FRACTION_BITS) > 17) ? (CW + FRACTION_BITS) : 17) + 2;
  localparam int SW    = 2 * DW;
  localparam int DSW   = DW + 2;
  localparam int RGW   = 20;

  localparam logic signed [RGW-1:0] RG_ZERO = '0;
  localparam logic signed [RGW-1:0] RG_TOP  = RGW'(BLOCK_WIDTH - 1);
  localparam logic signed [RGW-1:0] RG_ONE  = RGW'(1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]        radius_r;
  logic [CFG_W-1:0]        search_r;
  logic signed [POS_W-1:0] pos_r [3];
  logic [CELL_W-1:0]       cell_r;
  logic [AW-1:0]           clr_r;
  logic [CW-1:0]           lo_r [3];
  logic [CW-1:0]           hi_r [3];
  logic [CW-1:0]           idx_r [3];
  logic [1:0]              ax_r;
  logic [SW-1:0]           prod_r;
  logic [SW-1:0]           acc_r;

  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [CELL_W-1:0]         out_cell_r;

  logic                    in_acc;
  logic                    out_acc;
  logic                    out_load;
  logic signed [RGW-1:0]   lo_c [3];
  logic signed [RGW-1:0]   hi_c [3];
  logic                    empty_c;
  logic signed [DW-1:0]    off_c;
  logic signed [SW-1:0]    sq_c;
  logic [AW-1:0]           flat_c;
  logic [DW-1:0]           root;
  logic signed [DSW-1:0]   dsub_c;
  logic signed [STORE_W-1:0] dsat_c;
  logic signed [STORE_W-1:0] rd_c;
  logic                    lower_c;
  logic                    last_i, last_j, last_k;
  logic                    cell_ok_c;
  logic signed [STORE_W:0] neg_c;
  logic signed [VALUE_W-1:0] rval_c;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [STORE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [STORE_W-1:0] ram_rdata;

  sqrt_ctl_t sq_ctl;
  sqrt_sts_t sq_sts;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_valid_r && out_ch.ready;
  assign out_load = (state_r == S_RDATA) && !(out_valid_r && !out_ch.ready);

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      search_r <= SEARCH_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RADIUS: radius_r <= cfg_ch.data;
        REG_SEARCH: search_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // per-axis visited range
  always_comb begin
    logic signed [RGW-1:0] p, sr, a, b;
    empty_c = 1'b0;
    for (int n = 0; n < 3; n++) begin
      p  = RGW'(pos_r[n]);
      sr = signed'(RGW'(search_r));
      a  = (p - sr) >>> FRACTION_BITS;
      b  = ((p + sr) >>> FRACTION_BITS) + RG_ONE;
      lo_c[n] = (a < RG_ZERO) ? RG_ZERO : a;
      hi_c[n] = (b > RG_TOP) ? RG_TOP : b;
      if (lo_c[n] > hi_c[n]) begin
        empty_c = 1'b1;
      end
    end
  end

  // offset, square, flat index
  always_comb begin
    off_c  = (signed'(DW'(idx_r[ax_r])) <<< FRACTION_BITS) - DW'(pos_r[ax_r]);
    sq_c   = off_c * off_c;
    flat_c = AW'(int'(idx_r[0]) + BLOCK_WIDTH * (int'(idx_r[1])
             + BLOCK_WIDTH * int'(idx_r[2])));
  end

  // distance minus radius, saturated to the store range
  always_comb begin
    dsub_c = signed'({2'b00, root}) - signed'(DSW'(radius_r));
    if (dsub_c > DSW'(STORE_MAX)) begin
      dsat_c = STORE_MAX;
    end else if (dsub_c < DSW'(STORE_MIN)) begin
      dsat_c = STORE_MIN;
    end else begin
      dsat_c = STORE_W'(dsub_c);
    end
    rd_c    = signed'(ram_rdata);
    lower_c = dsat_c < rd_c;
    last_i  = idx_r[0] == hi_r[0];
    last_j  = idx_r[1] == hi_r[1];
    last_k  = idx_r[2] == hi_r[2];
  end

  // read result
  always_comb begin
    cell_ok_c = int'(cell_r) < CELLS;
    neg_c     = -{rd_c[STORE_W-1], rd_c};
    if (!cell_ok_c) begin
      rval_c = '0;
    end else if (neg_c > (STORE_W+1)'(VALUE_MAX)) begin
      rval_c = VALUE_MAX;
    end else if (neg_c < (STORE_W+1)'(VALUE_MIN)) begin
      rval_c = VALUE_MIN;
    end else begin
      rval_c = VALUE_W'(neg_c);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_ch.operation))
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_SPLAT: state_nxt = S_SETUP;
            OP_READ:  state_nxt = S_READ;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR:   if (clr_r == AW'(CELLS - 1)) state_nxt = S_IDLE;
      S_SETUP:   state_nxt = empty_c ? S_IDLE : S_MUL;
      S_MUL:     if (ax_r == 2'd2) state_nxt = S_SUM;
      S_SUM:     state_nxt = S_ROOT_GO;
      S_ROOT_GO: state_nxt = S_ROOT;
      S_ROOT:    if (sq_sts.done) state_nxt = S_UPDATE;
      S_UPDATE:  state_nxt = (last_i && last_j && last_k) ? S_IDLE : S_MUL;
      S_READ:    state_nxt = S_RDATA;
      S_RDATA:   if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = flat_c;
    ram_wdata    = STORE_W'(dsat_c);
    ram_re       = 1'b0;
    ram_raddr    = flat_c;
    sq_ctl.start = 1'b0;
    unique case (state_r)
      S_IDLE: in_ch.ready = 1'b1;
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = STORE_W'({radius_r, 1'b0}) + STORE_W'(radius_r);
      end
      S_SUM:     ram_re = 1'b1;
      S_ROOT_GO: sq_ctl.start = 1'b1;
      S_UPDATE:  ram_we = lower_c;
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(cell_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        pos_r[0] <= in_ch.pos_x;
        pos_r[1] <= in_ch.pos_y;
        pos_r[2] <= in_ch.pos_z;
        cell_r   <= in_ch.read_cell;
        clr_r    <= '0;
      end
      S_CLEAR: clr_r <= clr_r + 1'b1;
      S_SETUP: begin
        for (int n = 0; n < 3; n++) begin
          lo_r[n]  <= CW'(lo_c[n]);
          hi_r[n]  <= CW'(hi_c[n]);
          idx_r[n] <= CW'(lo_c[n]);
        end
        ax_r   <= '0;
        acc_r  <= '0;
        prod_r <= '0;
      end
      S_MUL: begin
        prod_r <= sq_c;
        acc_r  <= acc_r + prod_r;
        ax_r   <= ax_r + 1'b1;
      end
      S_SUM: acc_r <= acc_r + prod_r;
      S_UPDATE: begin
        ax_r   <= '0;
        acc_r  <= '0;
        prod_r <= '0;
        if (!last_i) begin
          idx_r[0] <= idx_r[0] + 1'b1;
        end else begin
          idx_r[0] <= lo_r[0];
          if (!last_j) begin
            idx_r[1] <= idx_r[1] + 1'b1;
          end else begin
            idx_r[1] <= lo_r[1];
            if (!last_k) begin
              idx_r[2] <= idx_r[2] + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= rval_c;
      out_cell_r  <= cell_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_value_r;
  assign out_ch.value_cell = out_cell_r;

  psds_ram #(
    .WIDTH (STORE_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psds_isqrt #(
    .RW (DW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .radicand (acc_r),
    .sts      (sq_sts),
    .root     (root)
  );

  `PSDS_ASSERT_SAME(a_store_write_src, ram_we, (state_r == S_CLEAR) || (state_r == S_UPDATE))
  `PSDS_ASSERT_SAME(a_root_done_state, sq_sts.done, state_r == S_ROOT)
  `PSDS_ASSERT_SAME(a_root_busy_state, sq_sts.busy, state_r == S_ROOT)
  `PSDS_ASSERT_NEXT(a_read_gives_beat, out_load, out_valid_r)
  `PSDS_ASSERT_SAME(a_walk_in_range, state_r == S_UPDATE, (idx_r[0] >= lo_r[0]) && (idx_r[0] <= hi_r[0]))

endmodule

### rtl/core/psds_ram.sv
module psds_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/psds_isqrt.sv
module psds_isqrt import psds_pkg::*; #(
  parameter int RW = 19
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sqrt_ctl_t       ctl,
  input  logic [2*RW-1:0] radicand,
  output sqrt_sts_t       sts,
  output logic [RW-1:0]   root
);

  localparam int SW   = 2 * RW;
  localparam int RMW  = RW + 3;
  localparam int CNTW = $clog2(RW + 1);

  logic [SW-1:0]   rad_r;
  logic [RMW-1:0]  rem_r;
  logic [RW-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic           ge;

  always_comb begin
    rem_sh = {rem_r[RMW-3:0], rad_r[SW-1:SW-2]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNTW'(RW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= rad_r << 2;
        rem_r  <= ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[RW-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule
